>>> sv/lsmt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsmt_pkg: shared types for the LCD scanline mode timer
// Beat payloads, timer state and the display mode codes.
// ----------------------------------------------------------------------------
package lsmt_pkg;

  // Width of the per-line cycle down-counter
  localparam int LineCntW = 9;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } lcd_mode_t;

  typedef struct packed {
    logic [7:0] cycles;
    logic       lcd_on;
    logic [7:0] compare_line;
    logic       irq_on_coincidence;
    logic       irq_on_oam;
    logic       irq_on_vblank;
    logic       irq_on_hblank;
    logic       hdma_hblank_active;
  } in_item_t;

  typedef struct packed {
    logic [7:0] current_line;
    lcd_mode_t  lcd_mode;
    logic       coincidence;
    logic       stat_irq;
    logic       vblank_irq;
    logic       render_line;
    logic [7:0] rendered_line;
    logic       hdma_chunk;
  } out_item_t;

  typedef struct packed {
    logic [LineCntW-1:0] line_cycles_left;
    logic [7:0]          line_number;
    logic                prev_status_level;
    logic                hdma_done_this_line;
  } timer_state_t;

endpackage
`default_nettype wire

>>> sv/lcd_scanline_mode_timer.sv
`default_nettype none
// An input beat reaches its result beat through the input register, then the
// result register.
// Throughput: one beat per cycle while out_ready holds; the timer state
// updates as each item moves from the input register to the result register.
// Reset: rst_n clears both stages and loads a full line count at line 0.
// ----------------------------------------------------------------------------
// lcd_scanline_mode_timer: scanline timer of an LCD controller
// Tracks line and per-line cycles, reports mode, STAT and VBlank pulses,
// line render requests and HBlank DMA chunk requests.
// ----------------------------------------------------------------------------
module lcd_scanline_mode_timer #(
  parameter int CYCLES_PER_LINE = 456,
  parameter int VISIBLE_LINES   = 144,
  parameter int LAST_LINE       = 153,
  parameter int OAM_CYCLES      = 82,
  parameter int TRANSFER_CYCLES = 172
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire  lsmt_pkg::in_item_t in_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output lsmt_pkg::out_item_t      out_data
);
  import lsmt_pkg::*;

  logic         s1_valid_r;
  in_item_t     s1_data_r;
  timer_state_t st_r;
  timer_state_t st_nxt;
  out_item_t    res;
  logic         out_valid_r;
  out_item_t    out_data_r;
  logic         advance;

  // Move the held item on when the result register is free or draining
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  lsmt_step #(
    .CYCLES_PER_LINE(CYCLES_PER_LINE),
    .VISIBLE_LINES  (VISIBLE_LINES),
    .LAST_LINE      (LAST_LINE),
    .OAM_CYCLES     (OAM_CYCLES),
    .TRANSFER_CYCLES(TRANSFER_CYCLES)
  ) u_step (
    .item  (s1_data_r),
    .st    (st_r),
    .st_nxt(st_nxt),
    .res   (res)
  );

  // Control and timer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r                 <= 1'b0;
      out_valid_r                <= 1'b0;
      st_r.line_cycles_left      <= LineCntW'(CYCLES_PER_LINE);
      st_r.line_number           <= 8'd0;
      st_r.prev_status_level     <= 1'b0;
      st_r.hdma_done_this_line   <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // Line counter never empties and never exceeds a full line
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.line_cycles_left != '0 &&
    st_r.line_cycles_left <= LineCntW'(CYCLES_PER_LINE))
    else $error("line cycle counter out of range");

  // VBlank pulse only with the line at the first blank line
  a_vbl_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.vblank_irq |->
    out_data_r.current_line == 8'(VISIBLE_LINES))
    else $error("vblank pulse on wrong line");

  // Rendered line is visible, and zero when nothing is drawn
  a_render: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
    (out_data_r.render_line && out_data_r.rendered_line < 8'(VISIBLE_LINES)) ||
    (!out_data_r.render_line && out_data_r.rendered_line == 8'd0))
    else $error("rendered line inconsistent");

  // DMA chunks only in HBlank
  a_chunk_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.hdma_chunk |-> out_data_r.lcd_mode == MODE_HBLANK)
    else $error("hdma chunk outside hblank");

  // A stalled item stays held in the input register
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r)
    else $error("held item dropped");
`endif

endmodule
`default_nettype wire

>>> sv/lsmt_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsmt_step: one timer update
// Derives mode, coincidence and STAT edge from the current state, then counts
// cycles down, advancing the line as it runs out; display off holds line 0.
// ----------------------------------------------------------------------------
module lsmt_step #(
  parameter int CYCLES_PER_LINE = 456,
  parameter int VISIBLE_LINES   = 144,
  parameter int LAST_LINE       = 153,
  parameter int OAM_CYCLES      = 82,
  parameter int TRANSFER_CYCLES = 172
) (
  input  wire  lsmt_pkg::in_item_t     item,
  input  wire  lsmt_pkg::timer_state_t st,
  output lsmt_pkg::timer_state_t       st_nxt,
  output lsmt_pkg::out_item_t          res
);
  import lsmt_pkg::*;

  localparam int OamEdge   = CYCLES_PER_LINE - OAM_CYCLES;
  localparam int XferEdge  = OamEdge - TRANSFER_CYCLES;
  // A threshold at or below zero is always met
  localparam logic [LineCntW-1:0] OamEdgeU  = LineCntW'(OamEdge);
  localparam logic [LineCntW-1:0] XferEdgeU = (XferEdge <= 0) ? '0 : LineCntW'(XferEdge);
  localparam logic [LineCntW-1:0] LineReload = LineCntW'(CYCLES_PER_LINE);
  localparam logic [7:0] VisLines = 8'(VISIBLE_LINES);
  localparam logic [7:0] LastLine = 8'(LAST_LINE);

  logic      visible;
  lcd_mode_t mode;
  logic      match;
  logic      level;
  logic      chunk;
  logic      expire;
  logic [7:0] line_inc;

  always_comb begin
    // Derive mode from line and remaining cycles
    visible = st.line_number < VisLines;
    if (!visible) begin
      mode = MODE_VBLANK;
    end else if (st.line_cycles_left >= OamEdgeU) begin
      mode = MODE_OAM;
    end else if (st.line_cycles_left >= XferEdgeU) begin
      mode = MODE_XFER;
    end else begin
      mode = MODE_HBLANK;
    end

    match = st.line_number == item.compare_line;
    level = (match && item.irq_on_coincidence) ||
            (mode == MODE_OAM && item.irq_on_oam) ||
            (mode == MODE_VBLANK && item.irq_on_vblank) ||
            (mode == MODE_HBLANK && item.irq_on_hblank);

    // One HBlank DMA chunk per visible line
    chunk = item.hdma_hblank_active && mode == MODE_HBLANK && visible &&
            !st.hdma_done_this_line;

    expire   = {1'b0, item.cycles} >= st.line_cycles_left;
    line_inc = st.line_number + 8'd1;

    st_nxt                     = st;
    st_nxt.prev_status_level   = level;
    st_nxt.hdma_done_this_line = st.hdma_done_this_line | chunk;

    res               = '0;
    res.lcd_mode      = mode;
    res.coincidence   = match;
    res.stat_irq      = level && !st.prev_status_level;
    res.hdma_chunk    = chunk;

    // Count down; finish the line when the time runs out
    if (expire) begin
      st_nxt.line_cycles_left    = LineReload;
      st_nxt.hdma_done_this_line = 1'b0;
      if (visible) begin
        res.render_line   = 1'b1;
        res.rendered_line = st.line_number;
      end
      if (line_inc == VisLines) begin
        res.vblank_irq      = 1'b1;
        st_nxt.line_number  = line_inc;
      end else if (line_inc > LastLine) begin
        st_nxt.line_number  = 8'd0;
      end else begin
        st_nxt.line_number  = line_inc;
      end
    end else begin
      st_nxt.line_cycles_left = st.line_cycles_left - {1'b0, item.cycles};
    end
    res.current_line = st_nxt.line_number;

    // Display off: hold line 0 in vblank, keep the DMA flag
    if (!item.lcd_on) begin
      st_nxt.line_cycles_left    = LineReload;
      st_nxt.line_number         = 8'd0;
      st_nxt.prev_status_level   = 1'b0;
      st_nxt.hdma_done_this_line = st.hdma_done_this_line;
      res                        = '0;
      res.lcd_mode               = MODE_VBLANK;
    end
  end

endmodule
`default_nettype wire
